### sv/iir_biquad_filter_core_defines.svh
// Assertion macros for the biquad filter RTL.
`ifndef IIR_BIQUAD_FILTER_CORE_DEFINES_SVH
`define IIR_BIQUAD_FILTER_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising edge outside reset.
`define BQF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("biquad filter assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BQF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("biquad filter assertion failed");

`else

`define BQF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BQF_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/bqf_pkg.sv
// Package with the widths, codes and types of the biquad filter.
`timescale 1ns / 1ps
`default_nettype none

package bqf_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_FILTER_ORDER = 2;
    localparam int DEF_SAMPLE_BITS  = 24;

    // Fixed number formats.
    localparam int COEF_BITS  = 32;
    localparam int DELAY_BITS = 32;
    localparam int FRAC_BITS  = 29;

    // Multiplier digit size and derived counts.
    localparam int DIGIT_BITS = 4;
    localparam int NUM_DIGITS = DELAY_BITS / DIGIT_BITS;
    localparam int CNT_W      = $clog2(NUM_DIGITS);
    localparam int ACC_W      = COEF_BITS + DIGIT_BITS + 2;

    // Rounded product and running sum widths.
    localparam int RND_W = COEF_BITS + DELAY_BITS - FRAC_BITS + 1;
    localparam int SUM_W = RND_W + 1;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_A1 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_A2 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_B0 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_B1 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_B2 = 3'd4;

    // Which coefficient product is being formed.
    typedef enum logic [2:0] {
        PROD_A1,
        PROD_A2,
        PROD_B0,
        PROD_B1,
        PROD_B2
    } t_prod;

    // Status reported by the serial multiplier.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_status;

endpackage

`default_nettype wire

### sv/bqf_if.sv
// Handshake interfaces for the sample, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface bqf_in_if #(
    parameter int SAMPLE_BITS = bqf_pkg::DEF_SAMPLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqf_out_if #(
    parameter int SAMPLE_BITS = bqf_pkg::DEF_SAMPLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_out;
    logic                   clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

interface bqf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bqf_pkg::CFG_IDX_BITS-1:0]  reg_index;
    logic [bqf_pkg::COEF_BITS-1:0]     wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

### sv/iir_biquad_filter_core.sv
// Top level of the fixed-point direct form II biquad filter.
`timescale 1ns / 1ps
`default_nettype none
`include "iir_biquad_filter_core_defines.svh"

// Second-order direct form II IIR filter for signed audio samples. For each
// sample x it forms w = x - R(a1*w1) - R(a2*w2), saturates w to 32 bits, then
// y = R(b0*w) + R(b1*w1) + R(b2*w2), saturated to SAMPLE_BITS, after which
// the delay line shifts (w2 takes w1, w1 takes w). Coefficients are signed
// 32-bit values with 29 fraction bits, a0 is fixed at one, and R rounds a
// product to the nearest integer with ties upward. The clipped flag is set
// when w or y saturated. All products go through one digit-serial multiplier
// that consumes four operand bits per cycle, and one sample is processed at
// a time. The result is held in an output register, so the next sample is
// accepted while the previous result waits to be taken. Coefficients are
// written through the configuration channel, which is always ready; writes
// to indexes above four are ignored and coefficients should only be changed
// while the filter idles.

module iir_biquad_filter_core #(
    parameter int FILTER_ORDER = bqf_pkg::DEF_FILTER_ORDER,
    parameter int SAMPLE_BITS  = bqf_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bqf_in_if.sink    i_in,
    bqf_out_if.source o_out,
    bqf_cfg_if.sink   i_cfg
);

    localparam int  SUM_W      = bqf_pkg::SUM_W;
    localparam int  RND_W      = bqf_pkg::RND_W;
    localparam int  DELAY_BITS = bqf_pkg::DELAY_BITS;
    localparam bit  HAS_SECOND = (FILTER_ORDER >= 2);

    // Sequencer states: wait for a sample, run a product, saturate the
    // intermediate value w, and hand the result to the output register.
    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_SATW,
        S_FIN
    } t_state;

    t_state                          r_state, n_state;
    bqf_pkg::t_prod                  r_idx, n_idx;
    logic                            r_start, n_start;
    logic signed [SUM_W-1:0]         r_sum, n_sum;
    logic signed [DELAY_BITS-1:0]    r_w, n_w;
    logic signed [DELAY_BITS-1:0]    r_w1, n_w1;
    logic signed [DELAY_BITS-1:0]    r_w2, n_w2;
    logic                            r_clip, n_clip;
    logic                            r_out_valid, n_out_valid;
    logic [SAMPLE_BITS-1:0]          r_out_sample, n_out_sample;
    logic                            r_out_clip, n_out_clip;

    logic signed [bqf_pkg::COEF_BITS-1:0] w_coef;
    logic signed [DELAY_BITS-1:0]         w_operand;
    bqf_pkg::t_mul_status                 w_status;
    logic signed [RND_W-1:0]              w_product;
    logic signed [SUM_W-1:0]              w_product_ext;
    logic                                 w_in_take;

    logic [SUM_W-DELAY_BITS:0]   w_w_top;
    logic                        w_w_ovf;
    logic signed [DELAY_BITS-1:0] w_w_sat;
    logic [SUM_W-SAMPLE_BITS:0]  w_y_top;
    logic                        w_y_ovf;
    logic [SAMPLE_BITS-1:0]      w_y_sat;

    bqf_coef_regs u_coef_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_sel   (r_idx),
        .o_coef  (w_coef)
    );

    // The delayed operand follows the product being formed.
    always_comb begin
        case (r_idx)
            bqf_pkg::PROD_A1: w_operand = r_w1;
            bqf_pkg::PROD_B1: w_operand = r_w1;
            bqf_pkg::PROD_A2: w_operand = r_w2;
            bqf_pkg::PROD_B2: w_operand = r_w2;
            bqf_pkg::PROD_B0: w_operand = r_w;
            default:          w_operand = r_w;
        endcase
    end

    bqf_digit_mult u_digit_mult (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_coef    (w_coef),
        .i_operand (w_operand),
        .o_status  (w_status),
        .o_product (w_product)
    );

    assign w_product_ext = {{(SUM_W-RND_W){w_product[RND_W-1]}}, w_product};

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_take  = i_in.valid && (r_state == S_IDLE);

    // Saturation of w to the delay word: in range when all bits from the
    // delay sign bit upward agree.
    assign w_w_top = r_sum[SUM_W-1:DELAY_BITS-1];
    assign w_w_ovf = !((&w_w_top) || !(|w_w_top));
    assign w_w_sat = w_w_ovf ? (r_sum[SUM_W-1] ? {1'b1, {(DELAY_BITS-1){1'b0}}}
                                               : {1'b0, {(DELAY_BITS-1){1'b1}}})
                             : r_sum[DELAY_BITS-1:0];

    // Saturation of y to the sample width.
    assign w_y_top = r_sum[SUM_W-1:SAMPLE_BITS-1];
    assign w_y_ovf = !((&w_y_top) || !(|w_y_top));
    assign w_y_sat = w_y_ovf ? (r_sum[SUM_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                               : {1'b0, {(SAMPLE_BITS-1){1'b1}}})
                             : r_sum[SAMPLE_BITS-1:0];

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_start      = 1'b0;
        n_sum        = r_sum;
        n_w          = r_w;
        n_w1         = r_w1;
        n_w2         = r_w2;
        n_clip       = r_clip;
        n_out_valid  = r_out_valid;
        n_out_sample = r_out_sample;
        n_out_clip   = r_out_clip;

        // A waiting result leaves when the sink takes it.
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    n_sum   = {{(SUM_W-SAMPLE_BITS){i_in.sample_in[SAMPLE_BITS-1]}},
                               i_in.sample_in};
                    n_idx   = bqf_pkg::PROD_A1;
                    n_start = 1'b1;
                    n_clip  = 1'b0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (w_status.done) begin
                    // Feedback products subtract, feedforward products add.
                    if (r_idx == bqf_pkg::PROD_A1 || r_idx == bqf_pkg::PROD_A2) begin
                        n_sum = r_sum - w_product_ext;
                    end else begin
                        n_sum = r_sum + w_product_ext;
                    end
                    case (r_idx)
                        bqf_pkg::PROD_A1: begin
                            if (HAS_SECOND) begin
                                n_idx   = bqf_pkg::PROD_A2;
                                n_start = 1'b1;
                            end else begin
                                n_state = S_SATW;
                            end
                        end
                        bqf_pkg::PROD_A2: begin
                            n_state = S_SATW;
                        end
                        bqf_pkg::PROD_B0: begin
                            n_idx   = bqf_pkg::PROD_B1;
                            n_start = 1'b1;
                        end
                        bqf_pkg::PROD_B1: begin
                            if (HAS_SECOND) begin
                                n_idx   = bqf_pkg::PROD_B2;
                                n_start = 1'b1;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_SATW: begin
                // The saturated w feeds the first feedforward product.
                n_w     = w_w_sat;
                n_clip  = w_w_ovf;
                n_sum   = '0;
                n_idx   = bqf_pkg::PROD_B0;
                n_start = 1'b1;
                n_state = S_MUL;
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = w_y_sat;
                    n_out_clip   = r_clip | w_y_ovf;
                    n_w2         = HAS_SECOND ? r_w1 : '0;
                    n_w1         = r_w;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= bqf_pkg::PROD_A1;
            r_start     <= 1'b0;
            r_w1        <= '0;
            r_w2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_start     <= n_start;
            r_w1        <= n_w1;
            r_w2        <= n_w2;
            r_out_valid <= n_out_valid;
        end
        r_sum        <= n_sum;
        r_w          <= n_w;
        r_clip       <= n_clip;
        r_out_sample <= n_out_sample;
        r_out_clip   <= n_out_clip;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.clipped    = r_out_clip;

    // A sample is only taken while the multiplier is quiet.
    `BQF_ASSERT_IMP(a_take_when_quiet, i_clk, i_rst_n, i_in.valid && i_in.ready, !w_status.busy && !r_start)
    // Product completions only arrive while the sequencer waits for one.
    `BQF_ASSERT_IMP(a_done_in_mul, i_clk, i_rst_n, w_status.done, r_state == S_MUL)
    // Every accepted sample issues the first feedback product.
    `BQF_ASSERT_NXT(a_take_starts, i_clk, i_rst_n, i_in.valid && i_in.ready, r_start && r_idx == bqf_pkg::PROD_A1)
    // A first-order build keeps the second delay word at zero.
    `BQF_ASSERT_IMP(a_order_one_w2, i_clk, i_rst_n, !HAS_SECOND, r_w2 == '0)

endmodule

`default_nettype wire

### sv/bqf_coef_regs.sv
// Coefficient register file with its write port and product selection.
`timescale 1ns / 1ps
`default_nettype none

module bqf_coef_regs (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    bqf_cfg_if.sink                                   i_cfg,
    input  wire bqf_pkg::t_prod                       i_sel,
    output logic signed [bqf_pkg::COEF_BITS-1:0]      o_coef
);

    logic signed [bqf_pkg::COEF_BITS-1:0] r_a1, r_a2, r_b0, r_b1, r_b2;

    // Writes are always taken; unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1 <= '0;
            r_a2 <= '0;
            r_b0 <= '0;
            r_b1 <= '0;
            r_b2 <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                bqf_pkg::CFG_A1: r_a1 <= $signed(i_cfg.wr_data);
                bqf_pkg::CFG_A2: r_a2 <= $signed(i_cfg.wr_data);
                bqf_pkg::CFG_B0: r_b0 <= $signed(i_cfg.wr_data);
                bqf_pkg::CFG_B1: r_b1 <= $signed(i_cfg.wr_data);
                bqf_pkg::CFG_B2: r_b2 <= $signed(i_cfg.wr_data);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_sel)
            bqf_pkg::PROD_A1: o_coef = r_a1;
            bqf_pkg::PROD_A2: o_coef = r_a2;
            bqf_pkg::PROD_B0: o_coef = r_b0;
            bqf_pkg::PROD_B1: o_coef = r_b1;
            bqf_pkg::PROD_B2: o_coef = r_b2;
            default:          o_coef = '0;
        endcase
    end

endmodule

`default_nettype wire

### sv/bqf_digit_mult.sv
// Digit-serial signed multiplier with round-to-nearest on the fraction bits.
`timescale 1ns / 1ps
`default_nettype none

module bqf_digit_mult (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic signed [bqf_pkg::COEF_BITS-1:0]  i_coef,
    input  wire logic signed [bqf_pkg::DELAY_BITS-1:0] i_operand,
    output bqf_pkg::t_mul_status                       o_status,
    output logic signed [bqf_pkg::RND_W-1:0]           o_product
);

    localparam int HI_W = bqf_pkg::RND_W - (bqf_pkg::DELAY_BITS - bqf_pkg::FRAC_BITS);
    localparam int DW   = bqf_pkg::DIGIT_BITS;

    logic                                  r_busy, n_busy;
    logic                                  r_fin, n_fin;
    logic                                  r_done, n_done;
    logic [bqf_pkg::CNT_W-1:0]             r_cnt, n_cnt;
    logic signed [bqf_pkg::COEF_BITS-1:0]  r_coef, n_coef;
    logic [bqf_pkg::DELAY_BITS-1:0]        r_mplr, n_mplr;
    logic signed [bqf_pkg::ACC_W-1:0]      r_acc, n_acc;
    logic [bqf_pkg::DELAY_BITS-1:0]        r_low, n_low;
    logic signed [bqf_pkg::RND_W-1:0]      r_prod, n_prod;

    logic                                  w_last;
    logic signed [DW:0]                    w_digit;
    logic signed [bqf_pkg::ACC_W-1:0]      w_partial;
    logic signed [bqf_pkg::ACC_W-1:0]      w_sum;

    // The top digit of the operand carries negative weight.
    assign w_last    = (r_cnt == bqf_pkg::CNT_W'(bqf_pkg::NUM_DIGITS - 1));
    assign w_digit   = $signed({w_last & r_mplr[DW-1], r_mplr[DW-1:0]});
    assign w_partial = r_coef * w_digit;
    assign w_sum     = r_acc + w_partial;

    always_comb begin
        n_busy = r_busy;
        n_fin  = 1'b0;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_coef = r_coef;
        n_mplr = r_mplr;
        n_acc  = r_acc;
        n_low  = r_low;
        n_prod = r_prod;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_coef = i_coef;
            n_mplr = i_operand;
            n_acc  = '0;
            n_low  = '0;
        end else if (r_busy) begin
            n_acc  = w_sum >>> DW;
            n_low  = {w_sum[DW-1:0], r_low[bqf_pkg::DELAY_BITS-1:DW]};
            n_mplr = r_mplr >> DW;
            n_cnt  = r_cnt + 1'b1;
            if (w_last) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end else if (r_fin) begin
            // floor((p + half) / 2^FRAC) is floor(p / 2^FRAC) plus the half bit.
            n_prod = $signed({r_acc[HI_W-1:0],
                              r_low[bqf_pkg::DELAY_BITS-1:bqf_pkg::FRAC_BITS]})
                     + $signed({{(bqf_pkg::RND_W-1){1'b0}}, r_low[bqf_pkg::FRAC_BITS-1]});
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_coef <= n_coef;
        r_mplr <= n_mplr;
        r_acc  <= n_acc;
        r_low  <= n_low;
        r_prod <= n_prod;
    end

    assign o_status.busy = r_busy | r_fin;
    assign o_status.done = r_done;
    assign o_product     = r_prod;

endmodule

`default_nettype wire

### bench/tb_iir_biquad_filter_core.sv
// Self-checking bench for the biquad filter core: a table of corner cases, then random phases.
`timescale 1ns / 1ps

module tb_iir_biquad_filter_core;

    import bqf_pkg::*;

    // The core is built with its default order and sample width, and the
    // predictor below follows the same two numbers.
    localparam int ORDER = DEF_FILTER_ORDER;
    localparam int SMP_W = DEF_SAMPLE_BITS;

    // Timing of the run. The watchdog covers the slowest correct run: about
    // 1025 samples, plus sender gaps, receiver stalls, the two long holds and
    // the coefficient phases.
    localparam int RESET_CYCLES   = 10;
    localparam int END_QUIET      = 128;
    localparam int PHASE_ITEMS    = 125;
    localparam int N_PHASES       = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AT_FIRST  = 200;
    localparam int HOLD_AT_SECOND = 700;

    // Register indexes above the last coefficient, which the core ignores.
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_HI = 3'd7;

    // Coefficients in the 3.29 format.
    localparam logic [COEF_BITS-1:0] COEF_ONE       = 32'h2000_0000;
    localparam logic [COEF_BITS-1:0] COEF_HALF      = 32'h1000_0000;
    localparam logic [COEF_BITS-1:0] COEF_MINUS_ONE = 32'hE000_0000;
    localparam logic [COEF_BITS-1:0] COEF_MAX       = 32'h7FFF_FFFF;
    localparam logic [COEF_BITS-1:0] COEF_MIN       = 32'h8000_0000;
    localparam logic [COEF_BITS-1:0] COEF_LSB       = 32'h0000_0001;

    // Sample extremes.
    localparam logic [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};
    localparam logic [SMP_W-1:0] SMP_NEG = '1;

    // Saturation bounds of the delay words and of the output.
    localparam longint DELAY_HI = (longint'(1) <<< (DELAY_BITS - 1)) - 1;
    localparam longint DELAY_LO = -DELAY_HI - 1;
    localparam longint SMP_HI   = (longint'(1) <<< (SMP_W - 1)) - 1;
    localparam longint SMP_LO   = -SMP_HI - 1;

    // One filtered sample as the result channel carries it.
    typedef struct packed {
        logic [SMP_W-1:0] sample;
        logic             clip;
    } t_filtered;

    // Rows of the directed table: a coefficient write, a sample whose result
    // is typed into the table, or a sample checked against the predictor.
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_TYPED,
        ROW_PREDICT
    } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_BITS-1:0] addr;
        logic [COEF_BITS-1:0]    data;
        logic [SMP_W-1:0]        x;
        logic [SMP_W-1:0]        want_y;
        logic                    want_clip;
    } t_row;

    // Coefficient flavours of the random phases.
    typedef enum logic [1:0] {
        MIX_STABLE,
        MIX_WILD,
        MIX_CORNER,
        MIX_PASS
    } t_mix;

    // Ready patterns of the result receiver.
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_HALF,
        SINK_SPARSE,
        SINK_PERIODIC
    } t_sink_mode;

    localparam int N_DIRECTED = 37;

    // The typed rows rely on all other coefficients still being zero, which
    // holds until the first feedback coefficient is written. After reset the
    // coefficients are zero, so every output is zero while the delay line
    // still fills. With b0 at one the filter passes samples straight through;
    // with b0 at one half the rounding ties go towards plus infinity; b0 at
    // either extreme drives the output into saturation. The last rows push
    // the delay words into saturation through extreme feedback, then write
    // two unused indexes, which must leave the coefficients untouched.
    localparam t_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{ROW_TYPED,   '0,            '0,             SMP_MAX,     '0,          1'b0},
        '{ROW_TYPED,   '0,            '0,             SMP_MIN,     '0,          1'b0},
        '{ROW_WRITE,   CFG_B0,        COEF_ONE,       '0,          '0,          1'b0},
        '{ROW_TYPED,   '0,            '0,             '0,          '0,          1'b0},
        '{ROW_TYPED,   '0,            '0,             SMP_MAX,     SMP_MAX,     1'b0},
        '{ROW_TYPED,   '0,            '0,             SMP_MIN,     SMP_MIN,     1'b0},
        '{ROW_TYPED,   '0,            '0,             SMP_W'(1),   SMP_W'(1),   1'b0},
        '{ROW_TYPED,   '0,            '0,             SMP_NEG,     SMP_NEG,     1'b0},
        '{ROW_WRITE,   CFG_B0,        COEF_HALF,      '0,          '0,          1'b0},
        '{ROW_TYPED,   '0,            '0,             SMP_W'(1),   SMP_W'(1),   1'b0},
        '{ROW_TYPED,   '0,            '0,             SMP_NEG,     '0,          1'b0},
        '{ROW_TYPED,   '0,            '0,             SMP_W'(3),   SMP_W'(2),   1'b0},
        '{ROW_TYPED,   '0,            '0,             SMP_W'(-3),  SMP_NEG,     1'b0},
        '{ROW_WRITE,   CFG_B0,        COEF_MAX,       '0,          '0,          1'b0},
        '{ROW_TYPED,   '0,            '0,             SMP_MAX,     SMP_MAX,     1'b1},
        '{ROW_TYPED,   '0,            '0,             SMP_MIN,     SMP_MIN,     1'b1},
        '{ROW_TYPED,   '0,            '0,             '0,          '0,          1'b0},
        '{ROW_WRITE,   CFG_B0,        COEF_MIN,       '0,          '0,          1'b0},
        '{ROW_TYPED,   '0,            '0,             SMP_MAX,     SMP_MIN,     1'b1},
        '{ROW_TYPED,   '0,            '0,             SMP_MIN,     SMP_MAX,     1'b1},
        '{ROW_WRITE,   CFG_B0,        COEF_ONE,       '0,          '0,          1'b0},
        '{ROW_WRITE,   CFG_A1,        COEF_MIN,       '0,          '0,          1'b0},
        '{ROW_WRITE,   CFG_B1,        COEF_MINUS_ONE, '0,          '0,          1'b0},
        '{ROW_PREDICT, '0,            '0,             SMP_MAX,     '0,          1'b0},
        '{ROW_PREDICT, '0,            '0,             SMP_MAX,     '0,          1'b0},
        '{ROW_PREDICT, '0,            '0,             SMP_MAX,     '0,          1'b0},
        '{ROW_PREDICT, '0,            '0,             SMP_MAX,     '0,          1'b0},
        '{ROW_PREDICT, '0,            '0,             SMP_MAX,     '0,          1'b0},
        '{ROW_WRITE,   CFG_A1,        COEF_MAX,       '0,          '0,          1'b0},
        '{ROW_WRITE,   CFG_A2,        COEF_MIN,       '0,          '0,          1'b0},
        '{ROW_WRITE,   CFG_B2,        COEF_MAX,       '0,          '0,          1'b0},
        '{ROW_PREDICT, '0,            '0,             SMP_MIN,     '0,          1'b0},
        '{ROW_PREDICT, '0,            '0,             SMP_MIN,     '0,          1'b0},
        '{ROW_PREDICT, '0,            '0,             SMP_MIN,     '0,          1'b0},
        '{ROW_WRITE,   CFG_UNUSED_LO, 32'hFFFF_FFFF,  '0,          '0,          1'b0},
        '{ROW_WRITE,   CFG_UNUSED_HI, COEF_MAX,       '0,          '0,          1'b0},
        '{ROW_PREDICT, '0,            '0,             '0,          '0,          1'b0}
    };

    logic i_clk;
    logic i_rst_n;

    bqf_in_if  #(.SAMPLE_BITS(SMP_W)) smp_in_bus ();
    bqf_out_if #(.SAMPLE_BITS(SMP_W)) smp_out_bus ();
    bqf_cfg_if                        coef_bus ();

    iir_biquad_filter_core #(
        .FILTER_ORDER(ORDER),
        .SAMPLE_BITS (SMP_W)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (smp_in_bus),
        .o_out  (smp_out_bus),
        .i_cfg  (coef_bus)
    );

    // The bench's own copy of the coefficients and the delay line, kept as
    // plain signed integers so that the sums below are exact.
    longint coef_a1, coef_a2, coef_b0, coef_b1, coef_b2;
    longint delay_one, delay_two;

    // Filtered samples still owed by the core, oldest first.
    t_filtered filtered_q [$];
    t_filtered oldest;
    int        error_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The coefficients and the delay line are zero after reset.
    initial begin
        coef_a1     = 0;
        coef_a2     = 0;
        coef_b0     = 0;
        coef_b1     = 0;
        coef_b2     = 0;
        delay_one   = 0;
        delay_two   = 0;
        error_count = 0;
    end

    // A product of a 3.29 coefficient and an integer, rounded to the nearest
    // integer with ties towards plus infinity. The arithmetic shift floors.
    function automatic longint round_q29(input longint coef, input longint val);
        longint prod;
        prod = coef * val + (longint'(1) <<< (FRAC_BITS - 1));
        return prod >>> FRAC_BITS;
    endfunction

    // Runs one sample through the bench's filter and advances its delay line.
    task automatic filter_step(input logic [SMP_W-1:0] x_raw, output t_filtered res);
        longint x;
        longint w;
        longint y;
        logic   clip;
        x    = longint'($signed(x_raw));
        clip = 1'b0;

        // Feedback part, saturated to the delay word before anything uses it.
        w = x - round_q29(coef_a1, delay_one);
        if (ORDER >= 2) begin
            w = w - round_q29(coef_a2, delay_two);
        end
        if (w > DELAY_HI) begin
            w    = DELAY_HI;
            clip = 1'b1;
        end else if (w < DELAY_LO) begin
            w    = DELAY_LO;
            clip = 1'b1;
        end

        // Feedforward part, saturated to the sample width.
        y = round_q29(coef_b0, w) + round_q29(coef_b1, delay_one);
        if (ORDER >= 2) begin
            y = y + round_q29(coef_b2, delay_two);
        end
        if (y > SMP_HI) begin
            y    = SMP_HI;
            clip = 1'b1;
        end else if (y < SMP_LO) begin
            y    = SMP_LO;
            clip = 1'b1;
        end

        delay_two  = (ORDER >= 2) ? delay_one : 0;
        delay_one  = w;
        res.sample = y[SMP_W-1:0];
        res.clip   = clip;
    endtask

    task automatic report_mismatch(input string field, input longint got_v,
                                   input longint want_v);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got_v, want_v);
        error_count++;
    endtask

    // Offers one sample and waits for its transaction. Valid is left high, so
    // the caller either offers the next sample at once or lowers valid itself.
    // The expectation is taken from the table when one is typed in there, but
    // the predictor always runs so that its delay line keeps in step.
    task automatic send_sample(input logic [SMP_W-1:0] x, input bit use_typed,
                               input t_filtered typed_res);
        t_filtered predicted;
        smp_in_bus.valid     <= 1'b1;
        smp_in_bus.sample_in <= x;
        @(posedge i_clk);
        while (!smp_in_bus.ready) begin
            @(posedge i_clk);
        end
        filter_step(x, predicted);
        filtered_q.push_back(use_typed ? typed_res : predicted);
    endtask

    // Writes one register and mirrors it into the predictor once the
    // transaction has taken place. Unused indexes change nothing.
    task automatic write_coef(input logic [CFG_IDX_BITS-1:0] idx,
                              input logic [COEF_BITS-1:0] val);
        coef_bus.valid     <= 1'b1;
        coef_bus.reg_index <= idx;
        coef_bus.wr_data   <= val;
        @(posedge i_clk);
        while (!coef_bus.ready) begin
            @(posedge i_clk);
        end
        case (idx)
            CFG_A1:  coef_a1 = longint'($signed(val));
            CFG_A2:  coef_a2 = longint'($signed(val));
            CFG_B0:  coef_b0 = longint'($signed(val));
            CFG_B1:  coef_b1 = longint'($signed(val));
            CFG_B2:  coef_b2 = longint'($signed(val));
            default: ;
        endcase
        coef_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Every sample gives exactly one result, so the core is idle as soon as
    // nothing is owed any more and the input valid is low.
    task automatic wait_drained();
        while (filtered_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Coefficients for the random phases. Stable sets keep both feedback
    // coefficients below one half in magnitude, so the filter decays; wild
    // sets take any 32-bit value; corner sets pick from the format's edges;
    // pass-through sets fix b0 at one with no feedback.
    function automatic logic [COEF_BITS-1:0] pick_coef(input t_mix mix,
                                                       input logic [CFG_IDX_BITS-1:0] idx);
        logic [COEF_BITS-1:0] corner [8];
        bit                   feedback;
        corner   = '{COEF_MIN, COEF_MAX, '0, COEF_ONE, COEF_MINUS_ONE, '1, COEF_LSB, COEF_HALF};
        feedback = (idx == CFG_A1) || (idx == CFG_A2);
        case (mix)
            MIX_STABLE: begin
                if (feedback) begin
                    return $urandom_range(0, 32'h1FFF_FFFE) - 32'h0FFF_FFFF;
                end
                return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
            end
            MIX_WILD:   return $urandom();
            MIX_CORNER: return corner[$urandom_range(0, 7)];
            default: begin
                if (feedback) begin
                    return '0;
                end
                if (idx == CFG_B0) begin
                    return COEF_ONE;
                end
                return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
            end
        endcase
    endfunction

    // Mostly full-range samples, with some extremes and some small values.
    function automatic logic [SMP_W-1:0] pick_sample();
        logic [SMP_W-1:0] corner [5];
        corner = '{SMP_MAX, SMP_MIN, '0, SMP_W'(1), SMP_NEG};
        case ($urandom_range(0, 7))
            0:       return corner[$urandom_range(0, 4)];
            1:       return SMP_W'($urandom_range(0, 511) - 256);
            default: return SMP_W'($urandom());
        endcase
    endfunction

    // Result receiver. Its ready follows one of several patterns, each kept
    // for a random stretch, and twice it holds off for a long stretch so that
    // the core fills its output register and then stalls its input.
    initial begin : result_sink
        int         taken;
        int         hold_left;
        int         mode_left;
        int         tick;
        t_sink_mode mode;
        taken     = 0;
        hold_left = 0;
        mode_left = 0;
        tick      = 0;
        mode      = SINK_OPEN;
        smp_out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (smp_out_bus.valid && smp_out_bus.ready) begin
                taken++;
                if (taken == HOLD_AT_FIRST || taken == HOLD_AT_SECOND) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (mode_left == 0) begin
                mode      = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(40, 200);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                smp_out_bus.ready <= 1'b0;
            end else begin
                case (mode)
                    SINK_OPEN:     smp_out_bus.ready <= 1'b1;
                    SINK_HALF:     smp_out_bus.ready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE:   smp_out_bus.ready <= ($urandom_range(0, 3) == 0);
                    SINK_PERIODIC: smp_out_bus.ready <= ((tick % 8) < 4);
                    default:       smp_out_bus.ready <= 1'b1;
                endcase
            end
        end
    end

    // Result checker. Values are sampled at the rising edge, before anything
    // driven on that edge takes effect, and each result transaction is held
    // against the oldest filtered sample still owed.
    always @(posedge i_clk) begin
        if (i_rst_n && smp_out_bus.valid && smp_out_bus.ready) begin
            if (filtered_q.size() == 0) begin
                report_mismatch("sample_out of a result with none owed",
                                longint'($signed(smp_out_bus.sample_out)), 0);
            end else begin
                oldest = filtered_q.pop_front();
                if (smp_out_bus.sample_out !== oldest.sample) begin
                    report_mismatch("sample_out", longint'($signed(smp_out_bus.sample_out)),
                                    longint'($signed(oldest.sample)));
                end
                if (smp_out_bus.clipped !== oldest.clip) begin
                    report_mismatch("clipped", longint'(smp_out_bus.clipped),
                                    longint'(oldest.clip));
                end
            end
        end
    end

    // Watchdog for a core that hangs or loses results.
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        t_filtered none;
        t_mix      mix;
        bit        gapped;
        int        sent;
        int        burst;
        int        gap;
        none = '0;

        // Every input is known from the first instant; reset is asserted and then
        // released once.
        i_rst_n              <= 1'b0;
        smp_in_bus.valid     <= 1'b0;
        smp_in_bus.sample_in <= '0;
        coef_bus.valid       <= 1'b0;
        coef_bus.reg_index   <= '0;
        coef_bus.wr_data     <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Samples go back to back; before a register write
        // the input valid drops and every owed result is collected, so the
        // core is idle when its coefficients change.
        for (int r = 0; r < N_DIRECTED; r++) begin
            case (DIRECTED_ROWS[r].kind)
                ROW_WRITE: begin
                    smp_in_bus.valid <= 1'b0;
                    wait_drained();
                    write_coef(DIRECTED_ROWS[r].addr, DIRECTED_ROWS[r].data);
                end
                ROW_TYPED: begin
                    send_sample(DIRECTED_ROWS[r].x, 1'b1,
                                t_filtered'{DIRECTED_ROWS[r].want_y, DIRECTED_ROWS[r].want_clip});
                end
                default: send_sample(DIRECTED_ROWS[r].x, 1'b0, none);
            endcase
        end
        smp_in_bus.valid <= 1'b0;

        // Random part. Each phase writes a fresh coefficient set while the
        // core is idle, sometimes touches an unused index too, and then sends
        // its samples in bursts. The first four phases cover every flavour of
        // coefficient set, and the second phase runs with no gaps at all.
        for (int phase = 0; phase < N_PHASES; phase++) begin
            mix    = (phase < 4) ? t_mix'(phase) : t_mix'($urandom_range(0, 3));
            gapped = (phase != 1) && ($urandom_range(0, 3) != 0);
            wait_drained();
            for (int r = CFG_A1; r <= CFG_B2; r++) begin
                write_coef(CFG_IDX_BITS'(r), pick_coef(mix, CFG_IDX_BITS'(r)));
            end
            if ($urandom_range(0, 1) == 1) begin
                write_coef(CFG_IDX_BITS'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                           $urandom());
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 16);
                for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
                    send_sample(pick_sample(), 1'b0, none);
                    sent++;
                end
                // Gaps are mostly short, but now and then longer than a whole
                // sample's processing, so that they land on every stage of it.
                if (gapped) begin
                    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 70)
                                                      : $urandom_range(1, 8);
                    smp_in_bus.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            smp_in_bus.valid <= 1'b0;
        end

        // Collect what is still owed, then allow a quiet spell in which any
        // stray result would still be caught.
        wait_drained();
        repeat (END_QUIET) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/bqf_pkg.sv
sv/bqf_if.sv
sv/bqf_coef_regs.sv
sv/bqf_digit_mult.sv
sv/iir_biquad_filter_core.sv
bench/tb_iir_biquad_filter_core.sv
